@@ rtl/lzc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzc_pkg: shared types and constants of the zero-crossing edge detector
// Sizes, register codes, the job record that runs between the front and the
// back, and the crossing score function.
// ----------------------------------------------------------------------------
package lzc_pkg;

  // frame geometry
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MIN_SIZE    = 3;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);

  // sample and score widths
  localparam int SAMPLE_BITS = 16;
  localparam int MAG_BITS    = SAMPLE_BITS + 1;
  localparam int SUM_BITS    = SAMPLE_BITS + 2;

  // register file
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 13;
  localparam int THRESH_BITS = 18;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(256);

  // output pixel values
  localparam int EDGE_BITS = 8;
  localparam logic [EDGE_BITS-1:0] EDGE_ON  = EDGE_BITS'(255);
  localparam logic [EDGE_BITS-1:0] EDGE_OFF = '0;

  // job queue
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]  width;
    logic [HEIGHT_BITS-1:0] height;
    logic [THRESH_BITS-1:0] thresh;
  } cfg_t;

  // one classified pixel: which beats it causes and their flags
  typedef struct packed {
    logic has_top;     // result for the row above
    logic top_edge;    // that result is an edge
    logic has_bottom;  // own border zero on the last row
    logic last_col;    // bottom beat closes the frame
  } job_t;

  // crossing strength between centre a (alt stands in when a is zero) and b
  function automatic logic [MAG_BITS-1:0] cross_score(sample_t a, sample_t alt, sample_t b);
    sample_t               ctr;
    logic [MAG_BITS-1:0]   ext_c;
    logic [MAG_BITS-1:0]   ext_b;
    logic [MAG_BITS-1:0]   mag_c;
    logic [MAG_BITS-1:0]   mag_b;
    logic [MAG_BITS-1:0]   score;
    ctr   = (a == '0) ? alt : a;
    ext_c = {ctr[SAMPLE_BITS-1], ctr};
    ext_b = {b[SAMPLE_BITS-1], b};
    mag_c = ctr[SAMPLE_BITS-1] ? (~ext_c + 1'b1) : ext_c;
    mag_b = b[SAMPLE_BITS-1] ? (~ext_b + 1'b1) : ext_b;
    if ((ctr == '0) || (b == '0) || (ctr[SAMPLE_BITS-1] == b[SAMPLE_BITS-1])) begin
      score = '0;
    end else begin
      score = mag_c + mag_b;
    end
    return score;
  endfunction

endpackage
`default_nettype wire

@@ rtl/lzc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzc_front: pixel intake, position tracking, line memory and scoring
// Accepts one pixel a cycle while the queue has room, reads both previous
// rows from line memory, scores crossings in the next cycle and queues a job.
// ----------------------------------------------------------------------------
module lzc_front (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire lzc_pkg::cfg_t                 cfg_i,
  input  wire                                s_valid_i,
  output logic                               s_ready_o,
  input  wire lzc_pkg::sample_t              s_sample_i,
  input  wire                                s_frame_start_i,
  input  wire [lzc_pkg::Q_CNT_BITS-1:0]      q_count_i,
  output logic                               job_push_o,
  output lzc_pkg::job_t                      job_o
);
  import lzc_pkg::*;

  // clamped frame size, as last index
  logic [WIDTH_BITS-1:0]  w_cl;
  logic [HEIGHT_BITS-1:0] h_cl;
  logic [WIDTH_BITS-1:0]  w_m1_full;
  logic [HEIGHT_BITS-1:0] h_m1_full;
  logic [COL_BITS-1:0]    w_m1;
  logic [ROW_BITS-1:0]    h_m1;

  always_comb begin
    priority if (cfg_i.width < WIDTH_BITS'(MIN_SIZE)) begin
      w_cl = WIDTH_BITS'(MIN_SIZE);
    end else if (cfg_i.width > WIDTH_BITS'(MAX_WIDTH)) begin
      w_cl = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      w_cl = cfg_i.width;
    end
    priority if (cfg_i.height < HEIGHT_BITS'(MIN_SIZE)) begin
      h_cl = HEIGHT_BITS'(MIN_SIZE);
    end else if (cfg_i.height > HEIGHT_BITS'(MAX_HEIGHT)) begin
      h_cl = HEIGHT_BITS'(MAX_HEIGHT);
    end else begin
      h_cl = cfg_i.height;
    end
  end

  assign w_m1_full = w_cl - 1'b1;
  assign h_m1_full = h_cl - 1'b1;
  assign w_m1      = w_m1_full[COL_BITS-1:0];
  assign h_m1      = h_m1_full[ROW_BITS-1:0];

  // position of the incoming pixel
  logic [COL_BITS-1:0] col_cnt_q, col_cnt_d;
  logic [ROW_BITS-1:0] row_cnt_q, row_cnt_d;
  logic [COL_BITS-1:0] col_eff, col_a, col_right;
  logic [ROW_BITS-1:0] row_eff, row_a;
  logic                accept;
  logic                b_valid_q;

  assign accept    = s_valid_i && s_ready_o;
  assign col_eff   = s_frame_start_i ? '0 : col_cnt_q;
  assign row_eff   = s_frame_start_i ? '0 : row_cnt_q;
  assign col_a     = (col_eff < w_m1) ? col_eff : w_m1;
  assign row_a     = (row_eff < h_m1) ? row_eff : h_m1;
  assign col_right = col_a + 1'b1;

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (accept) begin
      if (col_a == w_m1) begin
        col_cnt_d = '0;
        row_cnt_d = (row_a == h_m1) ? '0 : row_a + 1'b1;
      end else begin
        col_cnt_d = col_a + 1'b1;
        row_cnt_d = row_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      b_valid_q <= 1'b0;
    end else begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      b_valid_q <= accept;
    end
  end

  // room for the job in flight plus this one
  logic [Q_CNT_BITS:0] q_used;
  assign q_used    = {1'b0, q_count_i} + {{Q_CNT_BITS{1'b0}}, b_valid_q};
  assign s_ready_o = (q_used < (Q_CNT_BITS + 1)'(Q_DEPTH));

  // line memory: low half previous row, high half the row before
  logic [2*SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
  logic [2*SAMPLE_BITS-1:0] rd_cur_q;
  logic [2*SAMPLE_BITS-1:0] rd_right_q;
  logic                     wr_en;
  logic [COL_BITS-1:0]      wr_addr;
  logic [2*SAMPLE_BITS-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_cur_q   <= line_mem[col_a];
      rd_right_q <= line_mem[col_right];
    end
  end

  // scoring stage registers
  logic [COL_BITS-1:0]      b_col_q;
  sample_t                  b_sample_q;
  logic                     b_has_top_q;
  logic                     b_interior_q;
  logic                     b_has_bottom_q;
  logic                     b_last_col_q;
  logic                     fwd_cur_q;
  logic                     fwd_right_q;
  logic [2*SAMPLE_BITS-1:0] fwd_data_q;
  sample_t                  left_hold_q;

  // bypass for the write that lands on the same edge as the read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_col_q        <= col_a;
      b_sample_q     <= s_sample_i;
      b_has_top_q    <= (row_a != '0);
      b_interior_q   <= (row_a >= ROW_BITS'(2)) && (col_a != '0) && (col_a < w_m1);
      b_has_bottom_q <= (row_a == h_m1);
      b_last_col_q   <= (col_a == w_m1);
      fwd_cur_q      <= wr_en && (wr_addr == col_a);
      fwd_right_q    <= wr_en && (wr_addr == col_right);
      fwd_data_q     <= wr_data;
    end
  end

  logic [2*SAMPLE_BITS-1:0] cur;
  sample_t                  cur_prev;
  sample_t                  cur_prev2;
  sample_t                  right_prev;
  logic [MAG_BITS-1:0]      score_h;
  logic [MAG_BITS-1:0]      score_v;
  logic [SUM_BITS-1:0]      score_sum;

  assign cur        = fwd_cur_q ? fwd_data_q : rd_cur_q;
  assign cur_prev   = cur[SAMPLE_BITS-1:0];
  assign cur_prev2  = cur[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign right_prev = fwd_right_q ? fwd_data_q[SAMPLE_BITS-1:0]
                                  : rd_right_q[SAMPLE_BITS-1:0];

  assign score_h   = cross_score(cur_prev, left_hold_q, right_prev);
  assign score_v   = cross_score(cur_prev, cur_prev2, b_sample_q);
  assign score_sum = {1'b0, score_h} + {1'b0, score_v};

  // shift the column down one row and keep its old value as left neighbour
  assign wr_en   = b_valid_q;
  assign wr_addr = b_col_q;
  assign wr_data = {cur_prev, b_sample_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_hold_q <= '0;
    end else if (b_valid_q) begin
      left_hold_q <= cur_prev;
    end
  end

  // job for the back end
  assign job_push_o        = b_valid_q && (b_has_top_q || b_has_bottom_q);
  assign job_o.has_top     = b_has_top_q;
  assign job_o.top_edge    = b_interior_q && (score_sum > SUM_BITS'(cfg_i.thresh));
  assign job_o.has_bottom  = b_has_bottom_q;
  assign job_o.last_col    = b_last_col_q;

`ifndef SYNTHESIS
  a_start_col0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_frame_start_i) |=> (b_valid_q && (b_col_q == '0) && !b_has_top_q))
    else $error("frame start did not restart at column zero");
  a_interior_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_interior_q) |-> (b_has_top_q && !b_last_col_q && (b_col_q != '0)))
    else $error("interior pixel classified on a border");
  a_bottom_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_has_bottom_q) |-> b_has_top_q)
    else $error("last row pixel without a result for the row above");
`endif

endmodule
`default_nettype wire

@@ rtl/lzc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzc_queue: job queue between the front and the back
// Small register queue; the front only pushes when it reserved a slot.
// ----------------------------------------------------------------------------
module lzc_queue (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                push_i,
  input  wire lzc_pkg::job_t                 job_i,
  input  wire                                pop_i,
  output lzc_pkg::job_t                      job_o,
  output logic                               empty_o,
  output logic [lzc_pkg::Q_CNT_BITS-1:0]     count_o
);
  import lzc_pkg::*;

  job_t                  slots_q [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_q;
  logic [Q_PTR_BITS-1:0] rd_ptr_q;
  logic [Q_CNT_BITS-1:0] count_q;

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + Q_CNT_BITS'(push_i) - Q_CNT_BITS'(pop_i);
    end
  end

  assign job_o   = slots_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule
`default_nettype wire

@@ rtl/lzc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzc_back: result beat sequencer
// Turns each queued job into one or two output beats through a registered
// output stage.
// ----------------------------------------------------------------------------
module lzc_back (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                q_empty_i,
  input  wire lzc_pkg::job_t                 job_i,
  output logic                               pop_o,
  output logic                               m_valid_o,
  input  wire                                m_ready_i,
  output logic [lzc_pkg::EDGE_BITS-1:0]      m_edge_o,
  output logic                               m_bottom_o,
  output logic                               m_end_o
);
  import lzc_pkg::*;

  logic                 m_valid_q, m_valid_d;
  logic [EDGE_BITS-1:0] m_edge_q;
  logic                 m_bottom_q;
  logic                 m_end_q;
  logic                 phase_q, phase_d;
  logic                 load;
  logic                 top_beat;

  // top beat first, then the bottom border beat of the same job
  assign load     = !q_empty_i && (!m_valid_q || m_ready_i);
  assign top_beat = job_i.has_top && !phase_q;
  assign pop_o    = load && !(top_beat && job_i.has_bottom);

  always_comb begin
    phase_d   = phase_q;
    m_valid_d = m_valid_q && !m_ready_i;
    if (load) begin
      m_valid_d = 1'b1;
      phase_d   = top_beat && job_i.has_bottom;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      phase_q   <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
      phase_q   <= phase_d;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      m_edge_q   <= (top_beat && job_i.top_edge) ? EDGE_ON : EDGE_OFF;
      m_bottom_q <= !top_beat;
      m_end_q    <= !top_beat && job_i.last_col;
    end
  end

  assign m_valid_o  = m_valid_q;
  assign m_edge_o   = m_edge_q;
  assign m_bottom_o = m_bottom_q;
  assign m_end_o    = m_end_q;

endmodule
`default_nettype wire

@@ rtl/log_zero_crossing_edge_detector_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// log_zero_crossing_edge_detector_top: zero-crossing edge map of a filtered frame
// Register file, front end with line memory, job queue and result sequencer.
//
//   channel  | direction | tdata            | tuser       | tlast
//   ---------+-----------+------------------+-------------+----------
//   s_axis   | in        | log_sample[15:0] | frame_start | -
//   m_axis   | out       | edge_value[7:0]  | bottom_row  | frame_end
//   apb      | in/out    | 0 width, 4 height, 8 threshold
//
// One pixel per clock while the queue has room; a job is queued in the cycle
// after its beat and reaches the output register through a queue slot.
// On the last row every pixel causes two result beats, so the single output
// register paces the input there, emitting both beats of a job before the next.
// The four-entry job queue lets input and output stall independently.
// Reset is asynchronous; the line memory is not cleared, and its contents only
// affect results at columns already written in the frame.
// ----------------------------------------------------------------------------
module log_zero_crossing_edge_detector_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [15:0]                       s_axis_tdata,   // log_sample[15:0]
  input  wire [0:0]                        s_axis_tuser,   // frame_start
  // output stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [7:0]                       m_axis_tdata,   // edge_value[7:0]
  output logic [0:0]                       m_axis_tuser,   // bottom_row
  output logic                             m_axis_tlast,
  // register port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [lzc_pkg::ADDR_BITS-1:0]     paddr,
  input  wire [lzc_pkg::DATA_BITS-1:0]     pwdata,
  output logic [lzc_pkg::DATA_BITS-1:0]    prdata,
  output logic                             pready
);
  import lzc_pkg::*;

  // register file
  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= WIDTH_RESET;
      cfg_q.height <= HEIGHT_RESET;
      cfg_q.thresh <= THRESH_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WIDTH:  cfg_q.width  <= pwdata[WIDTH_BITS-1:0];
        REG_HEIGHT: cfg_q.height <= pwdata[HEIGHT_BITS-1:0];
        REG_THRESH: cfg_q.thresh <= pwdata[THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = DATA_BITS'(cfg_q.width);
      REG_HEIGHT: prdata = DATA_BITS'(cfg_q.height);
      REG_THRESH: prdata = DATA_BITS'(cfg_q.thresh);
      default:    prdata = '0;
    endcase
  end

  // front, queue and back
  logic                  job_push;
  job_t                  job_in;
  job_t                  job_head;
  logic                  q_pop;
  logic                  q_empty;
  logic [Q_CNT_BITS-1:0] q_count;

  lzc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .s_valid_i       (s_axis_tvalid),
    .s_ready_o       (s_axis_tready),
    .s_sample_i      (s_axis_tdata),
    .s_frame_start_i (s_axis_tuser[0]),
    .q_count_i       (q_count),
    .job_push_o      (job_push),
    .job_o           (job_in)
  );

  lzc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (q_pop),
    .job_o   (job_head),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  lzc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .job_i      (job_head),
    .pop_o      (q_pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_edge_o   (m_axis_tdata),
    .m_bottom_o (m_axis_tuser[0]),
    .m_end_o    (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> (q_count != Q_CNT_BITS'(Q_DEPTH)))
    else $error("job pushed into a full queue");
  a_pop_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");
  a_end_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[0] && (m_axis_tdata == EDGE_OFF)))
    else $error("frame end on a beat that is not a bottom border zero");
`endif

endmodule
`default_nettype wire
